[design/tes_pkg.sv]
// Shared types and codes for the timed event scheduler.
package tes_pkg;

  localparam int PAYLOAD_BITS = 41;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_START  = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RK_INSERTED = 2'd0,
    RK_FULL     = 2'd1,
    RK_BUSY     = 2'd2,
    RK_FIRED    = 2'd3
  } result_kind_t;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam logic       REG_PRECISION = 1'b0;
  localparam logic       REG_OUT_EN    = 1'b1;
  localparam logic [9:0] PRECISION_RESET = 10'd10;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] event_time;
    logic [1:0]  event_kind;
    logic [7:0]  note;
    logic [7:0]  velocity;
    logic [15:0] measure;
    logic [6:0]  percent;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  fired_kind;
    logic [7:0]  fired_note;
    logic [7:0]  fired_velocity;
    logic [15:0] fired_measure;
    logic [6:0]  fired_percent;
    logic        last;
  } out_word_t;

  // Payload layout as stored: percent, measure, velocity, note, kind.
  function automatic logic [PAYLOAD_BITS-1:0] pack_payload(in_word_t w);
    return {w.percent, w.measure, w.velocity, w.note, w.event_kind};
  endfunction

endpackage

[design/tes_fifo.sv]
// Small synchronous queue used for the command and result buffers.
module tes_fifo #(
  parameter int WIDTH = 8,
  parameter int LOG_DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int N = 1 << LOG_DEPTH;

  logic [WIDTH-1:0] mem [N];
  logic [LOG_DEPTH:0] wptr;
  logic [LOG_DEPTH:0] rptr;

  assign empty = (wptr == rptr);
  assign full  = (wptr[LOG_DEPTH-1:0] == rptr[LOG_DEPTH-1:0]) &&
                 (wptr[LOG_DEPTH] != rptr[LOG_DEPTH]);
  assign rdata = mem[rptr[LOG_DEPTH-1:0]];

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 1'b1;
      if (pop && !empty) rptr <= rptr + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr[LOG_DEPTH-1:0]] <= wdata;
  end
endmodule

[design/tes_engine.sv]
// Back end: sorted event table, insert shifting and tick playback.
module tes_engine #(
  parameter int DEPTH = 64,
  parameter int TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  tes_pkg::in_word_t cmd,
  input  logic              cmd_valid,
  output logic              cmd_take,
  input  logic [9:0]        precision,
  input  logic              out_en,
  output tes_pkg::out_word_t res,
  output logic              res_valid,
  input  logic              res_full
);
  import tes_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = IW + 1;
  localparam int EW = TIME_BITS + 1;
  localparam int MAX_RESULTS = 64;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_SHIFT_RD, S_SHIFT_WR, S_PLAY_RD, S_PLAY_CHK
  } state_t;

  logic [TIME_BITS-1:0]    time_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem  [DEPTH];

  state_t state;
  logic [CW-1:0] entry_count, play_index, ptr, spot;
  logic          playing;
  logic [EW-1:0] elapsed;
  logic [EW:0]   limit;
  logic [TIME_BITS-1:0]    new_time, rd_time;
  logic [PAYLOAD_BITS-1:0] new_pay, rd_pay;
  logic [6:0]    fired;
  logic          pend_valid;
  logic          pend_rdy;
  out_word_t     pend;

  // memory ports: one write, one registered read
  logic                    we;
  logic [IW-1:0]           waddr, raddr;
  logic [TIME_BITS-1:0]    wtime;
  logic [PAYLOAD_BITS-1:0] wpay;

  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr] <= wtime;
      pay_mem[waddr]  <= wpay;
    end
    rd_time <= time_mem[raddr];
    rd_pay  <= pay_mem[raddr];
  end

  // a fired word is held until the tick knows whether it is the last one
  assign cmd_take  = (state == S_IDLE) && cmd_valid && !pend_valid;
  assign res       = pend;
  assign res_valid = pend_valid && pend_rdy;

  logic [EW-1:0] elapsed_inc;
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + 1'b1;

  logic due;
  assign due = ({{(EW+1-TIME_BITS){1'b0}}, rd_time} <= limit);

  logic fire_ok;
  assign fire_ok = (rd_pay[1:0] != KIND_UNKNOWN) && out_en;

  // pending word control
  logic drain, ins_load, fire_load, tick_end, release_word, play_end;
  assign drain     = pend_valid && pend_rdy && !res_full;
  assign ins_load  = cmd_take && (opcode_t'(cmd.opcode) == OP_INSERT);
  assign play_end  = (ptr >= entry_count) || (fired == 7'(MAX_RESULTS));
  assign fire_load = (state == S_PLAY_CHK) && playing && due && fire_ok && !pend_valid;
  assign release_word = (state == S_PLAY_CHK) && playing && due && fire_ok &&
                        pend_valid && !pend_rdy;
  assign tick_end  = ((state == S_PLAY_RD) && play_end) ||
                     ((state == S_PLAY_CHK) && playing && !due);

  out_word_t ins_word, fire_word;

  always_comb begin
    ins_word = '0;
    ins_word.last = 1'b1;
    if (entry_count >= CW'(DEPTH)) ins_word.result_kind = RK_FULL;
    else if (playing) ins_word.result_kind = RK_BUSY;
    else ins_word.result_kind = RK_INSERTED;
    fire_word = '0;
    fire_word.result_kind = RK_FIRED;
    {fire_word.fired_percent, fire_word.fired_measure, fire_word.fired_velocity,
     fire_word.fired_note, fire_word.fired_kind} = rd_pay;
  end

  // read address and write port
  always_comb begin
    we    = 1'b0;
    waddr = ptr[IW-1:0];
    wtime = rd_time;
    wpay  = rd_pay;
    raddr = ptr[IW-1:0];
    if (state == S_SHIFT_RD && ptr == spot) begin
      we    = 1'b1;
      wtime = new_time;
      wpay  = new_pay;
    end else if (state == S_SHIFT_WR) begin
      we = 1'b1;
    end
    if (state == S_SHIFT_RD) raddr = IW'(ptr - 1'b1);
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      play_index <= '0;
      playing <= 1'b0;
      elapsed <= '0;
      pend_valid <= 1'b0;
      pend_rdy <= 1'b0;
      ptr <= '0;
    end else begin
      // pending result word
      if (ins_load) begin
        pend <= ins_word;
        pend_valid <= 1'b1;
        pend_rdy <= 1'b1;
      end else if (fire_load) begin
        pend <= fire_word;
        pend_valid <= 1'b1;
        pend_rdy <= 1'b0;
      end else if (tick_end && pend_valid) begin
        pend.last <= 1'b1;
        pend_rdy <= 1'b1;
      end else if (release_word) begin
        pend_rdy <= 1'b1;
      end else if (drain) begin
        pend_valid <= 1'b0;
      end

      case (state)
        S_IDLE: if (cmd_take) begin
          case (opcode_t'(cmd.opcode))
            OP_INSERT: begin
              if (entry_count < CW'(DEPTH) && !playing) begin
                new_time <= TIME_BITS'(cmd.event_time);
                new_pay  <= pack_payload(cmd);
                ptr <= '0;
                state <= S_SEARCH;
              end
            end
            OP_START: begin
              elapsed <= '0;
              play_index <= '0;
              playing <= (entry_count != '0);
            end
            OP_TICK: if (playing) begin
              elapsed <= elapsed_inc;
              limit <= {1'b0, elapsed_inc} + (EW+1)'(precision);
              ptr <= play_index;
              fired <= '0;
              state <= S_PLAY_RD;
            end
            default: begin
              entry_count <= '0;
              play_index <= '0;
              playing <= 1'b0;
            end
          endcase
        end
        // linear search for the first entry not earlier than the new one
        S_SEARCH: begin
          if (ptr >= entry_count) begin
            spot <= ptr;
            ptr <= entry_count;
            state <= S_SHIFT_RD;
          end else begin
            state <= S_PLAY_CHK;
          end
        end
        S_SHIFT_RD: begin
          if (ptr == spot) begin
            entry_count <= entry_count + 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          ptr <= ptr - 1'b1;
          state <= S_SHIFT_RD;
        end
        S_PLAY_RD: begin
          if (play_end) begin
            play_index <= ptr;
            if (ptr >= entry_count) playing <= 1'b0;
            state <= S_IDLE;
          end else begin
            state <= S_PLAY_CHK;
          end
        end
        S_PLAY_CHK: begin
          if (!playing) begin
            // search step shares this read slot
            if (rd_time < new_time) begin
              ptr <= ptr + 1'b1;
              state <= S_SEARCH;
            end else begin
              spot <= ptr;
              ptr <= entry_count;
              state <= S_SHIFT_RD;
            end
          end else if (!due) begin
            play_index <= ptr;
            state <= S_IDLE;
          end else if (fire_ok && pend_valid) begin
            // previous word is released and must drain first
            state <= S_PLAY_CHK;
          end else begin
            ptr <= ptr + 1'b1;
            state <= S_PLAY_RD;
            if (fire_ok) fired <= fired + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[design/timed_event_scheduler_top.sv]
// Top level of the timed event scheduler.
// Commands enter through push/full into a short command queue; the engine
// pops them one at a time. Results leave through empty/pop from a result
// queue; result words sit on the result ports while empty is low.
// Insert: the result word (inserted, full or busy) is registered in the
// engine and then passes through the result queue; the engine then searches
// and shifts the table. Start and clear: no result.
// Tick: each fired word is held until the next fired word or the end of the
// tick releases it; one word per fired event, last marks the final word. A
// tick that fires nothing emits nothing.
// Configuration writes are accepted every cycle on cfg_valid/cfg_ready.
// Reset empties the table and both queues and restores the registers.
// When the receiver stalls the result queue fills and the engine waits
// on its single pending word; commands keep queuing until full rises.
module timed_event_scheduler_top #(
  parameter int DEPTH = 64,
  parameter int TIME_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tes_pkg::in_word_t  in_word,
  output logic               full,
  input  logic               pop,
  output tes_pkg::out_word_t out_word,
  output logic               empty,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [9:0]         cfg_data
);
  import tes_pkg::*;

  logic [9:0] precision;
  logic       out_en;
  in_word_t   cmd;
  logic       cmd_empty, cmd_take;
  out_word_t  res;
  logic       res_valid, res_full;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      precision <= PRECISION_RESET;
      out_en <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PRECISION) precision <= cfg_data;
      if (cfg_index == REG_OUT_EN) out_en <= cfg_data[0];
    end
  end

  tes_fifo #(.WIDTH($bits(in_word_t)), .LOG_DEPTH(2)) u_cmd_q (
    .clk, .rst, .push, .wdata(in_word), .full,
    .pop(cmd_take), .rdata(cmd), .empty(cmd_empty)
  );

  tes_engine #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_engine (
    .clk, .rst, .cmd, .cmd_valid(!cmd_empty), .cmd_take,
    .precision, .out_en, .res, .res_valid, .res_full
  );

  tes_fifo #(.WIDTH($bits(out_word_t)), .LOG_DEPTH(2)) u_res_q (
    .clk, .rst, .push(res_valid), .wdata(res), .full(res_full),
    .pop, .rdata(out_word), .empty
  );
endmodule

[design/tes_checker.sv]
// Port-level checker for the timed event scheduler, bound to the top level.
module tes_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input tes_pkg::out_word_t out_word
);
  import tes_pkg::*;

  a_stable: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(out_word))
    else $error("result word changed while waiting");

  a_insert_last: assert property (@(posedge clk) disable iff (rst)
    !empty && out_word.result_kind != RK_FIRED |-> out_word.last)
    else $error("insert result without last");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not empty after reset");
endmodule

bind timed_event_scheduler_top tes_checker u_chk (
  .clk, .rst, .full, .pop, .empty, .out_word
);

[tb/tb.sv]
// Testbench for the timed event scheduler: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
  import tes_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam int MAX_FIRE  = 64;
  localparam logic [32:0] ELAPSED_MAX = {33{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  in_word_t in_word = '0;
  logic full;
  logic pop = 1'b0;
  out_word_t out_word;
  logic empty;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [9:0] cfg_data = '0;

  timed_event_scheduler_top dut (
    .clk(clk), .rst(rst), .push(push), .in_word(in_word), .full(full),
    .pop(pop), .out_word(out_word), .empty(empty), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scheduler shadow state
  logic [31:0] sched_time [TBL_DEPTH];
  logic [PAYLOAD_BITS-1:0] sched_payload [TBL_DEPTH];
  int unsigned sched_count = 0;
  int unsigned sched_index = 0;
  bit sched_playing = 0;
  logic [32:0] sched_elapsed = '0;
  logic [9:0] sched_precision = PRECISION_RESET;
  bit sched_out_en = 1'b1;

  out_word_t pending_words[$];
  int errors = 0;
  bit quiet_tail = 0;
  bit hold_pop = 0;

  function automatic out_word_t fired_word(logic [PAYLOAD_BITS-1:0] p);
    out_word_t w;
    w = '0;
    w.result_kind = RK_FIRED;
    w.fired_kind = p[1:0];
    w.fired_note = p[9:2];
    w.fired_velocity = p[17:10];
    w.fired_measure = p[33:18];
    w.fired_percent = p[40:34];
    return w;
  endfunction

  // Apply one command word to the shadow state, queue its result words
  task automatic predict_step(in_word_t w);
    out_word_t r;
    out_word_t batch[$];
    int unsigned spot;
    logic [33:0] limit;
    logic [PAYLOAD_BITS-1:0] p;
    batch = {};
    case (opcode_t'(w.opcode))
      OP_INSERT: begin
        r = '0;
        if (sched_count >= TBL_DEPTH) r.result_kind = RK_FULL;
        else if (sched_playing) r.result_kind = RK_BUSY;
        else begin
          spot = 0;
          while (spot < sched_count && sched_time[spot] < w.event_time) spot++;
          for (int i = sched_count; i > spot; i--) begin
            sched_time[i] = sched_time[i-1];
            sched_payload[i] = sched_payload[i-1];
          end
          sched_time[spot] = w.event_time;
          sched_payload[spot] = {w.percent, w.measure, w.velocity, w.note, w.event_kind};
          sched_count++;
          r.result_kind = RK_INSERTED;
        end
        batch.push_back(r);
      end
      OP_START: begin
        sched_elapsed = '0;
        sched_index = 0;
        sched_playing = sched_count > 0;
      end
      OP_TICK: begin
        if (sched_playing) begin
          if (sched_elapsed < ELAPSED_MAX) sched_elapsed++;
          limit = {1'b0, sched_elapsed} + sched_precision;
          while (sched_index < sched_count && sched_time[sched_index] <= limit
                 && batch.size() < MAX_FIRE) begin
            p = sched_payload[sched_index];
            sched_index++;
            if (p[1:0] == KIND_UNKNOWN || !sched_out_en) continue;
            batch.push_back(fired_word(p));
          end
          if (sched_index >= sched_count) sched_playing = 0;
        end
      end
      default: begin
        sched_count = 0;
        sched_index = 0;
        sched_playing = 0;
      end
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_words.push_back(batch[i]);
  endtask

  // Drive one command word and wait for acceptance; push drops on idling
  task automatic send_word(in_word_t w);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full);
    predict_step(w);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PRECISION) sched_precision = val;
    else sched_out_en = val[0];
    @(posedge clk);
  endtask

  function automatic in_word_t mk(opcode_t op, logic [31:0] t, logic [1:0] k,
                                  logic [7:0] n, logic [7:0] v, logic [15:0] m,
                                  logic [6:0] pc);
    in_word_t w;
    w.opcode = op; w.event_time = t; w.event_kind = k; w.note = n;
    w.velocity = v; w.measure = m; w.percent = pc;
    return w;
  endfunction

  function automatic in_word_t rand_insert(int unsigned tmax);
    return mk(OP_INSERT, ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, tmax),
              2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 16'($urandom),
              7'($urandom_range(0, 127)));
  endfunction

  // Result checker, with random and long receiver stalls
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && pop && !empty) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word %h", out_word);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        if (out_word.result_kind !== exp_w.result_kind) begin
          $error("result_kind exp %0d got %0d", exp_w.result_kind, out_word.result_kind);
          errors++;
        end
        if (out_word.fired_kind !== exp_w.fired_kind) begin
          $error("fired_kind exp %0d got %0d", exp_w.fired_kind, out_word.fired_kind);
          errors++;
        end
        if (out_word.fired_note !== exp_w.fired_note) begin
          $error("fired_note exp %0d got %0d", exp_w.fired_note, out_word.fired_note);
          errors++;
        end
        if (out_word.fired_velocity !== exp_w.fired_velocity) begin
          $error("fired_velocity exp %0d got %0d", exp_w.fired_velocity,
                 out_word.fired_velocity);
          errors++;
        end
        if (out_word.fired_measure !== exp_w.fired_measure) begin
          $error("fired_measure exp %0d got %0d", exp_w.fired_measure,
                 out_word.fired_measure);
          errors++;
        end
        if (out_word.fired_percent !== exp_w.fired_percent) begin
          $error("fired_percent exp %0d got %0d", exp_w.fired_percent,
                 out_word.fired_percent);
          errors++;
        end
        if (out_word.last !== exp_w.last) begin
          $error("last exp %0d got %0d", exp_w.last, out_word.last);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_pop) begin
        pop <= 1'b0;
        repeat (600) @(posedge clk);
        hold_pop = 0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        gap = $urandom_range(1, 15);
        repeat (gap) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Directed rows: command plus a typed-in result kind where obvious (-1 = predictor)
  typedef struct { in_word_t w; int exp_rk; } dir_row_t;

  initial begin
    dir_row_t rows[$];
    in_word_t w;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{mk(OP_TICK, 0, 0, 0, 0, 0, 0), -1});
    rows.push_back('{mk(OP_START, 0, 0, 0, 0, 0, 0), -1});
    rows.push_back('{mk(OP_INSERT, 32'hFFFFFFFF, 1, 8'hFF, 8'hFF, 16'hFFFF, 7'd100), RK_INSERTED});
    rows.push_back('{mk(OP_INSERT, 0, 0, 0, 0, 0, 0), RK_INSERTED});
    rows.push_back('{mk(OP_INSERT, 5, 2, 8'h55, 8'hAA, 16'h1234, 7'd50), RK_INSERTED});
    rows.push_back('{mk(OP_INSERT, 5, 0, 8'hAA, 8'h55, 16'hEDCB, 7'd127), RK_INSERTED});
    rows.push_back('{mk(OP_INSERT, 12, 3, 1, 2, 3, 4), RK_INSERTED});
    rows.push_back('{mk(OP_INSERT, 30, 1, 9, 9, 9, 9), RK_INSERTED});
    rows.push_back('{mk(OP_START, 0, 0, 0, 0, 0, 0), -1});
    rows.push_back('{mk(OP_INSERT, 1, 0, 0, 0, 0, 0), RK_BUSY});
    rows.push_back('{mk(OP_TICK, 0, 0, 0, 0, 0, 0), -1});
    rows.push_back('{mk(OP_TICK, 0, 0, 0, 0, 0, 0), -1});
    rows.push_back('{mk(OP_START, 0, 0, 0, 0, 0, 0), -1});
    rows.push_back('{mk(OP_TICK, 0, 0, 0, 0, 0, 0), -1});
    rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0, 0), -1});
    rows.push_back('{mk(OP_INSERT, 7, 0, 1, 1, 1, 1), RK_INSERTED});
    rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0, 0), -1});
    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].exp_rk >= 0 && pending_words.size() > 0 &&
          pending_words[pending_words.size()-1].result_kind != rows[i].exp_rk) begin
        $error("directed row %0d result_kind exp %0d", i, rows[i].exp_rk);
        errors++;
      end
    end
    wait_drained();

    // Fill to full with times 0 to 3, then overflow, fire all 64 on one tick
    write_reg(REG_PRECISION, 10'd1023);
    for (int i = 0; i < TBL_DEPTH + 2; i++)
      send_word(mk(OP_INSERT, 32'($urandom_range(0, 3)), 2'($urandom_range(0, 2)), 8'(i),
                   8'($urandom), 16'($urandom), 7'($urandom_range(0, 100))));
    hold_pop = 1;
    send_word(mk(OP_START, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 8; i++) send_word(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    wait_drained();
    send_word(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // Random phases across register settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_PRECISION, 10'((ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 1023 :
                $urandom_range(0, 40)));
      write_reg(REG_OUT_EN, (ph % 5 == 3) ? 10'd0 : 10'd1);
      if (ph >= 8) quiet_tail = 1;
      send_word(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
      repeat ($urandom_range(2, 12)) send_word(rand_insert(60));
      send_word(mk(OP_START, 0, 0, 0, 0, 0, 0));
      repeat ($urandom_range(8, 20)) begin
        case ($urandom_range(0, 19))
          0: w = mk(OP_START, 0, 0, 0, 0, 0, 0);
          1: w = mk(OP_CLEAR, 0, 0, 0, 0, 0, 0);
          2, 3: w = rand_insert(60);
          default: w = mk(OP_TICK, $urandom, 2'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom), 7'($urandom));
        endcase
        send_word(w);
      end
      wait_drained();
    end

    if (errors == 0 && pending_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
